// ===== rtl/assert_macros.svh =====
// assertion macros shared by the cobs frame encoder rtl
// depends on nothing; included by the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, checked outside reset
`define CFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/cfe_pkg.sv =====
// package for the cobs frame encoder: sequencer states and constants
// depends on nothing
package cfe_pkg;

    localparam int BYTE_W        = 8;
    localparam int MAX_FRAME_DEF = 60;

    localparam logic [BYTE_W-1:0] CODE_EMPTY_TAIL = 8'd1;
    localparam logic [BYTE_W-1:0] TERM_BYTE       = 8'd0;
    localparam logic [BYTE_W-1:0] ZERO_BYTE       = 8'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CODE,
        ST_DATA,
        ST_ONE,
        ST_TERM,
        ST_ERR
    } state_t;

endpackage

// ===== rtl/cfe_if.sv =====
// valid/ready channel interfaces for raw bytes in and encoded bytes out
// depends on cfe_pkg
interface cfe_in_if;
    logic                       valid;
    logic                       ready;
    logic [cfe_pkg::BYTE_W-1:0] in_byte;
    logic                       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface cfe_out_if;
    logic                       valid;
    logic                       ready;
    logic [cfe_pkg::BYTE_W-1:0] out_byte;
    logic                       is_frame_end;
    logic                       is_step_last;
    logic                       frame_too_long;

    modport source (output valid, output out_byte, output is_frame_end,
                    output is_step_last, output frame_too_long, input ready);
    modport sink   (input valid, input out_byte, input is_frame_end,
                    input is_step_last, input frame_too_long, output ready);
endinterface

// ===== rtl/cobs_frame_encoder.sv =====
// cobs frame encoder: a byte that opens or extends a run is taken while idle; a byte that
// closes a run of n held bytes holds ready low while the code, the held bytes, an optional
// trailing code and the terminator leave at one per cycle whenever tx.ready lets them
// the code is registered from ST_CODE once the output register can load; the data follows from ST_DATA
// an overlong frame yields a lone error transaction from ST_ERR; discarded bytes are taken with no output
// rst_n clears the sequencer, counters and output valid at once; the run buffer is not cleared
`include "assert_macros.svh"

module cobs_frame_encoder #(
    parameter int MAX_FRAME = cfe_pkg::MAX_FRAME_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cfe_in_if.sink    rx,
    cfe_out_if.source tx
);

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

    // run buffer port signals
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [cfe_pkg::BYTE_W-1:0] wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [cfe_pkg::BYTE_W-1:0] rd_data;

    // held non-zero bytes of the current run, written in order from entry zero
    cfe_ram #(
        .WIDTH (cfe_pkg::BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_run_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer: takes a transaction only when idle, then emits the code, the run and, at a frame's
    // end, an optional trailing code and the terminator, or an error byte, via its output register
    cfe_seq #(
        .MAX_FRAME (MAX_FRAME)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (rx.valid),
        .in_ready       (rx.ready),
        .in_byte        (rx.in_byte),
        .in_last        (rx.in_last),
        .out_valid      (tx.valid),
        .out_ready      (tx.ready),
        .out_byte       (tx.out_byte),
        .is_frame_end   (tx.is_frame_end),
        .is_step_last   (tx.is_step_last),
        .frame_too_long (tx.frame_too_long),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    // a terminator always closes the transaction group of its input byte
    `CFE_ASSERT_IMP(a_term_shape, clk, rst_n, tx.valid && tx.is_frame_end,
        tx.out_byte == cfe_pkg::TERM_BYTE && tx.is_step_last && !tx.frame_too_long)
    // the error transaction stands alone
    `CFE_ASSERT_IMP(a_err_shape, clk, rst_n, tx.valid && tx.frame_too_long,
        tx.is_step_last && !tx.is_frame_end && tx.out_byte == cfe_pkg::ZERO_BYTE)

endmodule

// ===== rtl/cfe_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing
module cfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cfe_alu.sv =====
// shared increment and compare unit used by the encoder sequencer
// depends on nothing
module cfe_alu #(
    parameter int CW = 6
) (
    input  logic [CW-1:0] op_a,
    input  logic [CW-1:0] op_b,
    output logic [CW-1:0] sum,
    output logic          hit
);

    // operand plus one; callers keep values below the top of the range
    assign sum = CW'(op_a + 1'b1);
    assign hit = (sum == op_b);

endmodule

// ===== rtl/cfe_seq.sv =====
// sequencer of the cobs frame encoder: frame and run counters, run buffer
// addressing and the output register; depends on cfe_pkg, cfe_alu, assert_macros.svh
`include "assert_macros.svh"

module cfe_seq #(
    parameter int MAX_FRAME = cfe_pkg::MAX_FRAME_DEF,
    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1,
    localparam int CW = $clog2(MAX_FRAME + 2)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // raw byte channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cfe_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    // encoded byte channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cfe_pkg::BYTE_W-1:0] out_byte,
    output logic                       is_frame_end,
    output logic                       is_step_last,
    output logic                       frame_too_long,
    // run buffer
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [cfe_pkg::BYTE_W-1:0] wr_data,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  logic [cfe_pkg::BYTE_W-1:0] rd_data
);

    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_FRAME);

    cfe_pkg::state_t state_reg, state_next;
    logic [CW-1:0] run_len_reg, run_len_next;
    logic [CW-1:0] frame_len_reg, frame_len_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          discard_reg, discard_next;
    logic          last_reg, last_next;
    logic          zero_reg, zero_next;

    logic                       out_valid_reg, out_valid_next;
    logic [cfe_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       frame_end_reg, frame_end_next;
    logic                       step_last_reg, step_last_next;
    logic                       too_long_reg, too_long_next;

    logic          load;
    logic          emit;
    logic [CW-1:0] alu_a;
    logic [CW-1:0] alu_b;
    logic [CW-1:0] alu_sum;
    logic          alu_hit;

    cfe_alu #(.CW(CW)) u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .sum  (alu_sum),
        .hit  (alu_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfe_pkg::ST_IDLE;
            run_len_reg   <= '0;
            frame_len_reg <= '0;
            idx_reg       <= '0;
            discard_reg   <= 1'b0;
            last_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_len_reg   <= run_len_next;
            frame_len_reg <= frame_len_next;
            idx_reg       <= idx_next;
            discard_reg   <= discard_next;
            last_reg      <= last_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
        step_last_reg <= step_last_next;
        too_long_reg  <= too_long_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        run_len_next   = run_len_reg;
        frame_len_next = frame_len_reg;
        idx_next       = idx_reg;
        discard_next   = discard_reg;
        last_next      = last_reg;
        zero_next      = zero_reg;

        load           = !out_valid_reg || out_ready;
        emit           = 1'b0;
        out_byte_next  = out_byte_reg;
        frame_end_next = 1'b0;
        step_last_next = 1'b0;
        too_long_next  = 1'b0;

        in_ready = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = run_len_reg[AW-1:0];
        wr_data  = in_byte;
        rd_en    = 1'b0;
        rd_addr  = '0;
        alu_a    = run_len_reg;
        alu_b    = run_len_reg;

        case (state_reg)
            cfe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (discard_reg)
                    begin
                        // drop bytes until the end of the overlong frame
                        if (in_last)
                        begin
                            discard_next   = 1'b0;
                            frame_len_next = '0;
                            run_len_next   = '0;
                        end
                    end
                    else if (frame_len_reg == MAX_LEN)
                    begin
                        state_next     = cfe_pkg::ST_ERR;
                        frame_len_next = '0;
                        run_len_next   = '0;
                        discard_next   = !in_last;
                    end
                    else
                    begin
                        frame_len_next = CW'(frame_len_reg + 1'b1);
                        last_next      = in_last;
                        zero_next      = (in_byte == cfe_pkg::ZERO_BYTE);
                        if (in_byte != cfe_pkg::ZERO_BYTE)
                        begin
                            if (run_len_reg != MAX_LEN)
                            begin
                                wr_en        = 1'b1;
                                run_len_next = alu_sum;
                            end
                            if (in_last)
                            begin
                                state_next = cfe_pkg::ST_CODE;
                            end
                        end
                        else
                        begin
                            state_next = cfe_pkg::ST_CODE;
                        end
                    end
                end
            end

            cfe_pkg::ST_CODE:
            begin
                if (load)
                begin
                    emit          = 1'b1;
                    out_byte_next = cfe_pkg::BYTE_W'(alu_sum);
                    if (run_len_reg == '0)
                    begin
                        if (last_reg)
                        begin
                            state_next = cfe_pkg::ST_ONE;
                        end
                        else
                        begin
                            step_last_next = 1'b1;
                            state_next     = cfe_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        // fetch the first held byte alongside the code
                        rd_en      = 1'b1;
                        idx_next   = '0;
                        state_next = cfe_pkg::ST_DATA;
                    end
                end
            end

            cfe_pkg::ST_DATA:
            begin
                alu_a = idx_reg;
                alu_b = run_len_reg;
                if (load)
                begin
                    emit          = 1'b1;
                    out_byte_next = rd_data;
                    if (alu_hit)
                    begin
                        run_len_next   = '0;
                        step_last_next = !last_reg;
                        if (!last_reg)
                        begin
                            state_next = cfe_pkg::ST_IDLE;
                        end
                        else if (zero_reg)
                        begin
                            state_next = cfe_pkg::ST_ONE;
                        end
                        else
                        begin
                            state_next = cfe_pkg::ST_TERM;
                        end
                    end
                    else
                    begin
                        idx_next = alu_sum;
                        rd_en    = 1'b1;
                        rd_addr  = alu_sum[AW-1:0];
                    end
                end
            end

            cfe_pkg::ST_ONE:
            begin
                if (load)
                begin
                    emit          = 1'b1;
                    out_byte_next = cfe_pkg::CODE_EMPTY_TAIL;
                    state_next    = cfe_pkg::ST_TERM;
                end
            end

            cfe_pkg::ST_TERM:
            begin
                if (load)
                begin
                    emit           = 1'b1;
                    out_byte_next  = cfe_pkg::TERM_BYTE;
                    frame_end_next = 1'b1;
                    step_last_next = 1'b1;
                    frame_len_next = '0;
                    run_len_next   = '0;
                    state_next     = cfe_pkg::ST_IDLE;
                end
            end

            cfe_pkg::ST_ERR:
            begin
                if (load)
                begin
                    emit           = 1'b1;
                    out_byte_next  = cfe_pkg::ZERO_BYTE;
                    too_long_next  = 1'b1;
                    step_last_next = 1'b1;
                    state_next     = cfe_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cfe_pkg::ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (!emit)
        begin
            frame_end_next = frame_end_reg;
            step_last_next = step_last_reg;
            too_long_next  = too_long_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign is_frame_end   = frame_end_reg;
    assign is_step_last   = step_last_reg;
    assign frame_too_long = too_long_reg;

    `CFE_ASSERT_IMP(a_run_fits, clk, rst_n, 1'b1, run_len_reg <= MAX_LEN)
    `CFE_ASSERT_IMP(a_drain_idx, clk, rst_n, state_reg == cfe_pkg::ST_DATA,
        idx_reg < run_len_reg)
    `CFE_ASSERT_NXT(a_overlong, clk, rst_n,
        in_valid && in_ready && !discard_reg && frame_len_reg == MAX_LEN,
        state_reg == cfe_pkg::ST_ERR && frame_len_reg == '0)

endmodule
